// File: hw/rtl/mpq_pkg.sv
// mpq_pkg: shared types and constants for the max priority queue
// no dependencies
package mpq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int DATA_BITS_DEF     = 32;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_TOP_RD,
    S_REPORT
  } eng_state_t;

endpackage

// File: hw/rtl/mpq_front.sv
// mpq_front: command intake and two-entry queue toward the heap engine
// depends on mpq_pkg
module mpq_front
  import mpq_pkg::*;
#(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int DATA_BITS     = DATA_BITS_DEF,
  localparam int W            = 1 + DATA_BITS + PRIORITY_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_word,
  output logic         q_valid,
  input  logic         q_ready,
  output logic [W-1:0] q_word
);

  logic [W-1:0] slot [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;
  logic         do_wr, do_rd;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_word   = slot[rd_ptr];
  assign do_wr    = in_valid && in_ready;
  assign do_rd    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= in_word;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// File: hw/rtl/mpq_engine.sv
// mpq_engine: heap memory with sift-up / sift-down sequencer and result register
// depends on mpq_pkg
module mpq_engine
  import mpq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int DATA_BITS     = DATA_BITS_DEF,
  localparam int W            = 1 + DATA_BITS + PRIORITY_BITS,
  localparam int AW           = $clog2(CAPACITY),
  localparam int CW           = $clog2(CAPACITY + 1),
  localparam int EW           = PRIORITY_BITS + DATA_BITS,
  localparam int RW           = 2 + 1 + DATA_BITS + PRIORITY_BITS + CW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [W-1:0]  q_word,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [RW-1:0] res_word
);

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_a, rd_b;
  logic [AW-1:0] ra_a, ra_b;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;
  logic          we2;
  logic [AW-1:0] wa2;
  logic [EW-1:0] wd2;

  eng_state_t state, state_next;
  logic [CW-1:0] count;
  logic [AW:0]   pos;
  logic [EW-1:0] cur;
  status_t       st;
  logic          have_res;

  // entry is {priority, data}
  function automatic logic signed [PRIORITY_BITS-1:0] prio_of(input logic [EW-1:0] e);
    prio_of = e[EW-1:DATA_BITS];
  endfunction

  cmd_t cmd_in;
  assign cmd_in = cmd_t'(q_word[0]);

  logic [AW:0] parent, lchild, rchild;
  assign parent = (pos - 1'b1) >> 1;
  assign lchild = {pos[AW-1:0], 1'b1};
  assign rchild = lchild + 1'b1;

  logic l_ok, r_ok, l_big, r_big, take_r;
  assign l_ok  = ({1'b0, lchild} < {1'b0, count});
  assign r_ok  = ({1'b0, rchild} < {1'b0, count});
  assign l_big = l_ok && (prio_of(rd_a) > prio_of(cur));
  assign r_big = r_ok && (l_big ? (prio_of(rd_b) > prio_of(rd_a))
                                : (prio_of(rd_b) > prio_of(cur)));
  assign take_r = r_big;

  // two-port read, registered
  always_ff @(posedge clk) begin
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
    if (we)  mem[wa]  <= wd;
    if (we2) mem[wa2] <= wd2;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid && !have_res) begin
          if (cmd_in == CMD_PUSH) begin
            state_next = (count == CW'(CAPACITY)) ? S_TOP_RD : S_UP_RD;
          end else begin
            state_next = (count == '0) ? S_REPORT : S_DN_RD;
          end
        end
      end
      S_UP_RD:  state_next = (pos == '0) ? S_TOP_RD : S_UP_CMP;
      S_UP_CMP: state_next = (prio_of(rd_a) < prio_of(cur)) ? S_UP_RD : S_TOP_RD;
      S_DN_RD:  state_next = S_DN_CMP;
      S_DN_CMP: state_next = (l_big || r_big) ? S_DN_RD : S_TOP_RD;
      S_TOP_RD: state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == S_IDLE) && !have_res;
    we = 1'b0; wa = '0; wd = cur;
    ra_a = '0; ra_b = '0;
    unique case (state)
      S_IDLE: begin
        // pop: fetch the last entry for the root
        ra_a = AW'(count - 1'b1);
      end
      S_UP_RD: begin
        ra_a = parent[AW-1:0];
        if (pos == '0) begin
          we = 1'b1; wa = '0;
        end
      end
      S_UP_CMP: begin
        we = 1'b1; wa = pos[AW-1:0];
        wd = (prio_of(rd_a) < prio_of(cur)) ? rd_a : cur;
      end
      S_DN_RD: begin
        ra_a = lchild[AW-1:0];
        ra_b = rchild[AW-1:0];
      end
      S_DN_CMP: begin
        we = 1'b1; wa = pos[AW-1:0];
        wd = take_r ? rd_b : (l_big ? rd_a : cur);
      end
      S_TOP_RD: begin
        ra_a = '0;
      end
      S_REPORT: ;
      default: ;
    endcase
  end

  logic [1:0] rcnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      have_res <= 1'b0;
      rcnt     <= '0;
    end else begin
      state <= state_next;
      if (have_res && res_ready) have_res <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && !have_res) begin
            if (cmd_in == CMD_PUSH) begin
              if (count == CW'(CAPACITY)) begin
                st <= ST_FULL;
              end else begin
                st    <= ST_DONE;
                cur   <= q_word[W-1:1] >> 0;
                pos   <= (AW+1)'(count);
                count <= count + 1'b1;
              end
            end else begin
              if (count == '0) begin
                st <= ST_EMPTY;
              end else begin
                st    <= ST_DONE;
                pos   <= '0;
                count <= count - 1'b1;
              end
            end
          end
          rcnt <= '0;
        end
        S_UP_CMP: begin
          if (prio_of(rd_a) < prio_of(cur)) pos <= parent;
        end
        S_DN_RD: begin
          // root value arrives from memory on the first pass
          if (rcnt == 2'd0) begin
            cur  <= rd_a;
            rcnt <= 2'd1;
          end
        end
        S_DN_CMP: begin
          if (take_r) pos <= rchild;
          else if (l_big) pos <= lchild;
          if (!(l_big || r_big)) begin
            // final place of the moving entry
          end
        end
        S_REPORT: begin
          have_res <= 1'b1;
          res_word <= {count,
                       (count == '0) ? {EW{1'b0}} : rd_a,
                       (count != '0), st};
        end
        default: ;
      endcase
    end
  end

  // last write for sift-down end and sift-up end both land above; the down
  // path must also put cur at its final slot
  always_comb begin
    we2 = 1'b0; wa2 = pos[AW-1:0]; wd2 = cur;
    if (state == S_DN_CMP && (l_big || r_big)) begin
      we2 = 1'b1;
      wa2 = take_r ? rchild[AW-1:0] : lchild[AW-1:0];
    end
  end

  assign res_valid = have_res;

endmodule

// File: hw/rtl/max_priority_queue.sv
// max_priority_queue: top level, front intake queue plus heap engine
// depends on mpq_pkg, mpq_front, mpq_engine
//
// binary max-heap priority queue of (priority, data) entries held in an
// on-chip memory of CAPACITY entries. every input item (push or pop) gives
// exactly one result item with status, the top entry after the operation
// and the entry count. a push to a full queue reports full, a pop on an
// empty queue reports empty, and neither changes the queue. items pass a
// two-entry intake queue, then a sequencer works on one at a time: a push
// climbs and a pop descends at most log2(CAPACITY) levels of the heap;
// each level takes a memory read state and a compare/write state on the
// two-port heap memory.
// equal priorities leave in no defined order.
module max_priority_queue
  import mpq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int DATA_BITS     = DATA_BITS_DEF,
  localparam int IW  = 1 + DATA_BITS + PRIORITY_BITS,
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int RW  = 2 + 1 + DATA_BITS + PRIORITY_BITS + CW,
  localparam int IWB = ((IW + 7) / 8) * 8,
  localparam int RWB = ((RW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  // cmd, item_data, item_priority
  input  logic [IWB-1:0] s_tdata,
  output logic           m_tvalid,
  input  logic           m_tready,
  // status, top_valid, top_data, top_priority, entry_count
  output logic [RWB-1:0] m_tdata
);

  logic          q_valid, q_ready;
  logic [IW-1:0] q_word;
  logic [RW-1:0] r_word;

  // intake repacks to {priority, data, cmd} so entries are {priority, data}
  logic [IW-1:0] in_word;
  assign in_word = {s_tdata[IW-1:1+DATA_BITS], s_tdata[DATA_BITS:1], s_tdata[0]};

  mpq_front #(
    .PRIORITY_BITS(PRIORITY_BITS),
    .DATA_BITS    (DATA_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_word  (q_word)
  );

  mpq_engine #(
    .CAPACITY     (CAPACITY),
    .PRIORITY_BITS(PRIORITY_BITS),
    .DATA_BITS    (DATA_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_word   (q_word),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res_word (r_word)
  );

  // engine packs {count, priority, data, top_valid, status}: same order
  assign m_tdata = {{(RWB-RW){1'b0}}, r_word};

endmodule

// File: test/max_priority_queue_test.sv
// max_priority_queue_test: self-checking bench for the heap priority queue
// depends on mpq_pkg and max_priority_queue; drives push/pop items, predicts
// every result with its own heap and compares field by field
`timescale 1ns / 100ps

module max_priority_queue_test;
  import mpq_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int PW = PRIORITY_BITS_DEF;
  localparam int DW = DATA_BITS_DEF;
  localparam int IW = 1 + DW + PW;
  localparam int IWB = ((IW + 7) / 8) * 8;
  localparam int CW = $clog2(CAP + 1);
  localparam int RW = 2 + 1 + DW + PW + CW;
  localparam int RWB = ((RW + 7) / 8) * 8;

  typedef struct packed {
    logic [CW-1:0] entry_count;
    logic signed [PW-1:0] top_priority;
    logic [DW-1:0] top_data;
    logic top_valid;
    status_t status;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IWB-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [RWB-1:0] m_tdata;

  always #6 clk = ~clk;

  max_priority_queue u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predicted heap
  logic signed [PW-1:0] heap_prio [CAP];
  logic [DW-1:0] heap_data [CAP];
  int heap_count = 0;

  logic [IWB-1:0] pending_items[$];
  result_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int pushes_seen = 0;
  int pops_seen = 0;
  bit quiet_phase = 1'b0;
  bit hold_receiver = 1'b0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;

  function automatic void swap_entries(int a, int b);
    logic signed [PW-1:0] p;
    logic [DW-1:0] d;
    p = heap_prio[a]; heap_prio[a] = heap_prio[b]; heap_prio[b] = p;
    d = heap_data[a]; heap_data[a] = heap_data[b]; heap_data[b] = d;
  endfunction

  // apply one operation to the predicted heap and return its result
  function automatic result_t apply_heap_op(logic [IWB-1:0] it);
    result_t r;
    int pos, up, best, l, rt;
    cmd_t op;
    op = cmd_t'(it[0]);
    r = '0;
    r.status = ST_DONE;
    if (op == CMD_PUSH) begin
      if (heap_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_count;
        heap_data[pos] = it[DW:1];
        heap_prio[pos] = it[DW+PW:DW+1];
        heap_count++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (!(heap_prio[up] < heap_prio[pos])) break;
          swap_entries(pos, up);
          pos = up;
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        heap_count--;
        heap_prio[0] = heap_prio[heap_count];
        heap_data[0] = heap_data[heap_count];
        pos = 0;
        forever begin
          best = pos;
          l = 2 * pos + 1;
          rt = 2 * pos + 2;
          if (l < heap_count && heap_prio[l] > heap_prio[best]) best = l;
          if (rt < heap_count && heap_prio[rt] > heap_prio[best]) best = rt;
          if (best == pos) break;
          swap_entries(pos, best);
          pos = best;
        end
      end
    end
    if (heap_count > 0) begin
      r.top_valid = 1'b1;
      r.top_data = heap_data[0];
      r.top_priority = heap_prio[0];
    end
    r.entry_count = CW'(heap_count);
    return r;
  endfunction

  function automatic logic [IWB-1:0] make_item(cmd_t op, logic [DW-1:0] d,
                                               logic [PW-1:0] p);
    logic [IWB-1:0] it;
    it = '0;
    it[0] = op;
    it[DW:1] = d;
    it[DW+PW:DW+1] = p;
    return it;
  endfunction

  function automatic logic [PW-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return PW'($urandom_range(0, 7));       // many ties
      1: return {1'b1, (PW-1)'($urandom)};       // negative
      default: return PW'($urandom);
    endcase
  endfunction

  // driver: valid drops only after acceptance, idle bursts between items
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(pending_items.pop_front());
        if (!quiet_phase && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 4);
      end
      if (s_tvalid && !in_taken) begin
        // item still waiting, hold it
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_sender) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_items[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // prediction at acceptance, sampled on the rising edge
  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) begin
      if (s_tdata[0] == CMD_PUSH) pushes_seen++; else pops_seen++;
      expected_results.push_back(apply_heap_op(s_tdata));
    end
  end

  // receiver stall pattern
  int recv_gap = 0;
  always @(negedge clk) begin
    if (rst || hold_receiver) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RW-1:0];
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.top_valid !== want.top_valid ||
            got.top_data !== want.top_data || got.top_priority !== want.top_priority ||
            got.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d v=%0b d=%h p=%0d n=%0d,",
                      " got st=%0d v=%0b d=%h p=%0d n=%0d"},
                     want.status, want.top_valid, want.top_data, want.top_priority,
                     want.entry_count, got.status, got.top_valid, got.top_data,
                     got.top_priority, got.entry_count);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // sender pause until the block has answered every accepted item
  task automatic wait_drained_partial();
    while (s_tvalid || expected_results.size() > 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int fill, n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pop, extremes, ties, drain past empty
    pending_items.push_back(make_item(CMD_POP, '1, '1));
    pending_items.push_back(make_item(CMD_PUSH, '0, {1'b1, {(PW-1){1'b0}}}));
    pending_items.push_back(make_item(CMD_PUSH, '1, {1'b0, {(PW-1){1'b1}}}));
    pending_items.push_back(make_item(CMD_PUSH, 32'h5555_aaaa, '0));
    pending_items.push_back(make_item(CMD_PUSH, 32'haaaa_5555, '0));
    pending_items.push_back(make_item(CMD_PUSH, 32'h1, '1));
    repeat (6) pending_items.push_back(make_item(CMD_POP, '0, '0));
    wait_drained();

    // long receiver hold while the sender offers pushes past capacity
    hold_receiver = 1'b1;
    for (int i = 0; i < CAP + 4; i++)
      pending_items.push_back(make_item(CMD_PUSH, DW'($urandom), rand_prio()));
    repeat (400) @(posedge clk);
    hold_receiver = 1'b0;
    wait_drained();
    for (int i = 0; i < CAP + 2; i++)
      pending_items.push_back(make_item(CMD_POP, DW'($urandom), PW'($urandom)));
    wait_drained();

    // random: fill/drain sweeps with mixed phases
    n = 0;
    while (n < 1000) begin
      fill = $urandom_range(20, 80);
      for (int i = 0; i < fill; i++) begin
        if ($urandom_range(0, 99) < (n % 200 < 100 ? 70 : 30))
          pending_items.push_back(make_item(CMD_PUSH, DW'($urandom), rand_prio()));
        else
          pending_items.push_back(make_item(CMD_POP, DW'($urandom), PW'($urandom)));
        n++;
      end
      if (n > 850) quiet_phase = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        hold_sender = 1'b1;
        wait_drained_partial();
        hold_sender = 1'b0;
      end
      while (pending_items.size() > 20) @(posedge clk);
    end
    wait_drained();
    repeat (60) @(posedge clk);
    $display("covered %0d pushes and %0d pops, %0d results checked", pushes_seen,
             pops_seen, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               expected_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_front.sv
hw/rtl/mpq_engine.sv
hw/rtl/max_priority_queue.sv
test/max_priority_queue_test.sv
